@@ design/fibr_pkg.sv @@
// Shared types, constants and codes for the fault breaker with backoff recovery.
`timescale 1ns / 1ps
`default_nettype none

package fibr_pkg;

   localparam int NUM_UNITS_DEF         = 16;
   localparam int TIME_WIDTH_DEF        = 32;
   localparam int BACKOFF_SHIFT_CAP_DEF = 5;

   localparam int UNIT_ID_W  = 4;
   localparam int NOW_W      = 32;
   localparam int MASK_W     = 16;
   localparam int COUNT_W    = 8;
   localparam int COOLDOWN_W = 16;
   localparam int BACKOFF_W  = 32;

   localparam int REQ_DATA_W = 40;   // unit_id + now_time, padded to bytes
   localparam int RSP_DATA_W = 48;   // 43 bits of fields, padded to bytes
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_RETRY_LIMIT   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_COOLDOWN      = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_BACKOFF   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ATTEMPT_LIMIT = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_AUTO_MASK     = 3'd4;

   // register reset values
   localparam logic [COUNT_W-1:0]    RETRY_LIMIT_RST   = 8'd3;
   localparam logic [COOLDOWN_W-1:0] COOLDOWN_RST      = 16'd1000;
   localparam logic [BACKOFF_W-1:0]  MAX_BACKOFF_RST   = 32'd60000;
   localparam logic [COUNT_W-1:0]    ATTEMPT_LIMIT_RST = 8'd0;
   localparam logic [MASK_W-1:0]     AUTO_MASK_RST     = 16'hFFFF;

   typedef enum logic [1:0] {
      MODE_FAULT   = 2'd0,
      MODE_TIME    = 2'd1,
      MODE_RST_ONE = 2'd2,
      MODE_RST_ALL = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UNIT,
      ST_FAULT,
      ST_SWEEP,
      ST_LOOK,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic [COUNT_W-1:0]    retry_limit;
      logic [COOLDOWN_W-1:0] cooldown_ticks;
      logic [BACKOFF_W-1:0]  max_backoff_ticks;
      logic [COUNT_W-1:0]    attempt_limit;
      logic [MASK_W-1:0]     auto_mask;
   } cfg_type;

endpackage

`default_nettype wire

@@ design/fibr_rec_mem.sv @@
// Unit record table: one write port, one registered read port, per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none

module fibr_rec_mem #(
   parameter int DEPTH  = 16,
   parameter int AW     = 4,
   parameter int DATA_W = 48
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // an entry never written reads as the all-zero reset record
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/fibr_engine.sv @@
// Sequencer: read-modify-write of unit records, enable bits and the result register.
`timescale 1ns / 1ps
`default_nettype none

module fibr_engine
   import fibr_pkg::*;
#(
   parameter int NUM_UNITS         = NUM_UNITS_DEF,
   parameter int TIME_WIDTH        = TIME_WIDTH_DEF,
   parameter int BACKOFF_SHIFT_CAP = BACKOFF_SHIFT_CAP_DEF,
   parameter int IW                = 4,
   parameter int RW                = TIME_WIDTH + 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfg_type               cfg,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire mode_type              req_mode,
   input  wire logic [UNIT_ID_W-1:0]  req_unit,
   input  wire logic [NOW_W-1:0]      req_now,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [RSP_DATA_W-1:0] rsp_data,
   output logic                       mem_rd_en,
   output logic      [IW-1:0]         mem_rd_addr,
   input  wire logic [RW-1:0]         mem_rd_data,
   output logic                       mem_wr_en,
   output logic      [IW-1:0]         mem_wr_addr,
   output logic      [RW-1:0]         mem_wr_data
);

   localparam int TW   = TIME_WIDTH;
   localparam int CW   = $clog2(NUM_UNITS + 1);
   localparam int NW   = (TW > NOW_W) ? TW : NOW_W;
   localparam int SHW  = $clog2(BACKOFF_SHIFT_CAP + 1);
   localparam int BW   = COOLDOWN_W + BACKOFF_SHIFT_CAP;
   localparam int CMPW = (BW > BACKOFF_W) ? BW : BACKOFF_W;
   localparam int SW   = ((TW > BACKOFF_W) ? TW : BACKOFF_W) + 1;

   state_type              state_ff, state_in;
   mode_type               mode_ff, mode_in;
   logic [UNIT_ID_W-1:0]   uid_ff, uid_in;
   logic [TW-1:0]          last_ff, last_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [NUM_UNITS-1:0]   en_ff, en_in;
   logic [MASK_W-1:0]      recov_ff, recov_in;
   logic                   just_ff, just_in;
   logic [COUNT_W-1:0]     fcnt_ff, fcnt_in;
   logic [COUNT_W-1:0]     att_ff, att_in;
   logic [TW-1:0]          due_ff, due_in;
   logic                   hit_ff, hit_in;
   logic [BACKOFF_W-1:0]   boff_ff, boff_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [COUNT_W-1:0]     d_cnt, d_att, att_inc, cnt_inc;
   logic [TW-1:0]          d_due, due_new;
   logic [IW-1:0]          uidx, pidx;
   logic                   uid_valid;
   logic [NUM_UNITS-1:0]   allow_vec, p_hot;
   logic [MASK_W-1:0]      en16, p_hot16;
   logic [NW-1:0]          now_ext;
   logic [COOLDOWN_W-1:0]  base;
   logic [SHW-1:0]         sh;
   logic [CMPW-1:0]        shifted;
   logic [SW-1:0]          due_sum;
   logic                   d_left, elig, exh;
   logic [COUNT_W-1:0]     ucount;

   assign d_cnt   = mem_rd_data[COUNT_W-1:0];
   assign d_att   = mem_rd_data[2*COUNT_W-1:COUNT_W];
   assign d_due   = mem_rd_data[RW-1:2*COUNT_W];
   assign att_inc = (d_att == 8'hFF) ? d_att : d_att + 8'd1;
   assign cnt_inc = (d_cnt == 8'hFF) ? d_cnt : d_cnt + 8'd1;
   assign d_left  = (cfg.attempt_limit == '0) || (d_att < cfg.attempt_limit);

   assign uidx      = IW'(uid_ff);
   assign uid_valid = (32'(uid_ff) < 32'(NUM_UNITS));
   assign pidx      = IW'(cnt_ff - CW'(1));
   assign p_hot     = NUM_UNITS'(1) << pidx;
   assign now_ext   = NW'(req_now);

   // only the first sixteen units have a mask bit or a place in the masks
   for (genvar i = 0; i < NUM_UNITS; i++) begin : g_allow
      if (i < MASK_W) begin : g_bit
         assign allow_vec[i] = cfg.auto_mask[i];
      end else begin : g_none
         assign allow_vec[i] = 1'b0;
      end
   end
   for (genvar i = 0; i < MASK_W; i++) begin : g_mask16
      if (i < NUM_UNITS) begin : g_bit
         assign en16[i]    = en_ff[i];
         assign p_hot16[i] = p_hot[i];
      end else begin : g_none
         assign en16[i]    = 1'b0;
         assign p_hot16[i] = 1'b0;
      end
   end

   // backoff = max(cooldown,1) << min(attempts, cap), clipped to the cap register
   assign base    = (cfg.cooldown_ticks == '0) ? COOLDOWN_W'(1) : cfg.cooldown_ticks;
   assign sh      = (d_att > 8'(BACKOFF_SHIFT_CAP)) ? SHW'(BACKOFF_SHIFT_CAP) : SHW'(d_att);
   assign shifted = CMPW'(base) << sh;

   // retry time saturates at the top of the time range
   assign due_sum = SW'(last_ff) + SW'(boff_ff);
   assign due_new = (due_sum[SW-1:TW] != '0) ? '1 : due_sum[TW-1:0];

   assign elig   = !en_ff[pidx] && allow_vec[pidx] && d_left && (last_ff >= d_due);
   assign exh    = uid_valid && !en_ff[uidx] && allow_vec[uidx] &&
                   (cfg.attempt_limit != '0) && (d_att >= cfg.attempt_limit);
   assign ucount = uid_valid ? d_cnt : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         en_ff        <= '1;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         en_ff        <= en_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      uid_ff      <= uid_in;
      cnt_ff      <= cnt_in;
      recov_ff    <= recov_in;
      just_ff     <= just_in;
      fcnt_ff     <= fcnt_in;
      att_ff      <= att_in;
      due_ff      <= due_in;
      hit_ff      <= hit_in;
      boff_ff     <= boff_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      uid_in       = uid_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      en_in        = en_ff;
      recov_in     = recov_ff;
      just_in      = just_ff;
      fcnt_in      = fcnt_ff;
      att_in       = att_ff;
      due_in       = due_ff;
      hit_in       = hit_ff;
      boff_in      = boff_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = uidx;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = uidx;
      mem_wr_data  = {d_due, d_att, COUNT_W'(0)};

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mode_in     = req_mode;
               uid_in      = req_unit;
               cnt_in      = '0;
               recov_in    = '0;
               just_in     = 1'b0;
               mem_rd_en   = 1'b1;
               mem_rd_addr = IW'(req_unit);
               if (req_mode == MODE_TIME) begin
                  last_in = now_ext[TW-1:0];
               end
               if (req_mode inside {MODE_TIME, MODE_RST_ALL}) begin
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_UNIT;
               end
            end
         end
         ST_UNIT: begin
            if (mode_ff == MODE_FAULT) begin
               fcnt_in  = cnt_inc;
               att_in   = d_att;
               due_in   = d_due;
               hit_in   = (cnt_inc >= cfg.retry_limit);
               boff_in  = (shifted > CMPW'(cfg.max_backoff_ticks)) ?
                          cfg.max_backoff_ticks : shifted[BACKOFF_W-1:0];
               state_in = ST_FAULT;
            end else begin
               if (uid_valid) begin
                  mem_wr_en    = 1'b1;
                  en_in[uidx]  = 1'b1;
               end
               state_in = ST_LOOK;
            end
         end
         ST_FAULT: begin
            if (uid_valid) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = {hit_ff ? due_new : due_ff, att_ff, fcnt_ff};
               if (hit_ff) begin
                  en_in[uidx] = 1'b0;
                  just_in     = 1'b1;
               end
            end
            state_in = ST_LOOK;
         end
         ST_SWEEP: begin
            // read entry cnt while writing back entry cnt-1
            if (32'(cnt_ff) < 32'(NUM_UNITS)) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = IW'(cnt_ff);
            end
            if (cnt_ff != '0) begin
               mem_wr_addr = pidx;
               if (mode_ff == MODE_TIME) begin
                  if (elig) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_data = {d_due, att_inc, COUNT_W'(0)};
                     en_in[pidx] = 1'b1;
                     recov_in    = recov_ff | p_hot16;
                  end
               end else begin
                  mem_wr_en   = 1'b1;
                  en_in[pidx] = 1'b1;
               end
            end
            cnt_in = cnt_ff + CW'(1);
            if (32'(cnt_ff) == 32'(NUM_UNITS)) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            mem_rd_en = 1'b1;
            state_in  = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({exh, recov_ff, just_ff, ucount, ~&en_ff, en16});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ design/fault_isolation_backoff_recovery_core.sv @@
// Top level: stream ports, register file, sequencer and unit record table.
// A fault report passes the unit, fault, look and finish states; a single reset passes
// unit, look and finish; time update and reset all sweep the table, one table entry per cycle.
// Only one transaction is in work at a time: a new request is taken only in the idle state,
// and a finished result may wait in the output register.
// Reset is synchronous: all units enabled, counts and times zero, registers at defaults.
`timescale 1ns / 1ps
`default_nettype none

module fault_isolation_backoff_recovery_core
   import fibr_pkg::*;
#(
   parameter int NUM_UNITS         = NUM_UNITS_DEF,
   parameter int TIME_WIDTH        = TIME_WIDTH_DEF,
   parameter int BACKOFF_SHIFT_CAP = BACKOFF_SHIFT_CAP_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // unit_id[3:0], now_time[35:4]
   input  wire logic [1:0]            req_tuser,  // mode[1:0]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // enabled_mask[15:0], any_disabled[16], unit_fault_count[24:17],
   // just_disabled[25], recovered_mask[41:26], recovery_exhausted[42]
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
   localparam int RW = TIME_WIDTH + 2 * COUNT_W;

   cfg_type           cfg_ff, cfg_in;
   logic              mem_rd_en, mem_wr_en;
   logic [IW-1:0]     mem_rd_addr, mem_wr_addr;
   logic [RW-1:0]     mem_rd_data, mem_wr_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_RETRY_LIMIT:   cfg_in.retry_limit       = csr_wdata[COUNT_W-1:0];
            CSR_COOLDOWN:      cfg_in.cooldown_ticks    = csr_wdata[COOLDOWN_W-1:0];
            CSR_MAX_BACKOFF:   cfg_in.max_backoff_ticks = csr_wdata[BACKOFF_W-1:0];
            CSR_ATTEMPT_LIMIT: cfg_in.attempt_limit     = csr_wdata[COUNT_W-1:0];
            CSR_AUTO_MASK:     cfg_in.auto_mask         = csr_wdata[MASK_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_limit       <= RETRY_LIMIT_RST;
         cfg_ff.cooldown_ticks    <= COOLDOWN_RST;
         cfg_ff.max_backoff_ticks <= MAX_BACKOFF_RST;
         cfg_ff.attempt_limit     <= ATTEMPT_LIMIT_RST;
         cfg_ff.auto_mask         <= AUTO_MASK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fibr_engine #(
      .NUM_UNITS         (NUM_UNITS),
      .TIME_WIDTH        (TIME_WIDTH),
      .BACKOFF_SHIFT_CAP (BACKOFF_SHIFT_CAP),
      .IW                (IW),
      .RW                (RW)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_mode    (mode_type'(req_tuser)),
      .req_unit    (req_tdata[UNIT_ID_W-1:0]),
      .req_now     (req_tdata[UNIT_ID_W+NOW_W-1:UNIT_ID_W]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_data    (rsp_tdata),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   fibr_rec_mem #(
      .DEPTH  (NUM_UNITS),
      .AW     (IW),
      .DATA_W (RW)
   ) u_rec_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

@@ design/fibr_checker.sv @@
// Port-level checks for the breaker core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fibr_checker
   import fibr_pkg::*;
#(
   parameter int NUM_UNITS = NUM_UNITS_DEF
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int LOW_N = (NUM_UNITS < MASK_W) ? NUM_UNITS : MASK_W;
   localparam logic [MASK_W-1:0] LOW_MASK = MASK_W'((32'd1 << LOW_N) - 32'd1);

   logic [MASK_W-1:0] en_mask, rec_mask;
   logic              any_dis, just_dis, exhausted;

   assign en_mask   = rsp_tdata[15:0];
   assign any_dis   = rsp_tdata[16];
   assign just_dis  = rsp_tdata[25];
   assign rec_mask  = rsp_tdata[41:26];
   assign exhausted = rsp_tdata[42];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction taken while one is in work");

   a_all_enabled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !any_dis |-> en_mask == LOW_MASK)
      else $error("no unit disabled but enable mask incomplete");

   a_recovered: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rec_mask != '0 |-> ((rec_mask & ~en_mask) == '0) && !just_dis)
      else $error("recovered unit not enabled or mixed with a trip");

   a_tripped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (just_dis || exhausted) |-> any_dis)
      else $error("tripped or exhausted unit without any unit disabled");

endmodule

bind fault_isolation_backoff_recovery_core fibr_checker #(
   .NUM_UNITS (NUM_UNITS)
) u_fibr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

@@ tb/sv/fibr_tb_pkg.sv @@
// Scoreboard for the fault breaker: expected-status predictor and response checker.
`timescale 1ns / 1ps

package fibr_tb_pkg;

   import fibr_pkg::*;

   // one response, highest field first so that it matches the rsp_tdata layout
   typedef struct packed {
      logic              exhausted;
      logic [MASK_W-1:0] recovered_mask;
      logic              just_disabled;
      logic [COUNT_W-1:0] fault_count;
      logic              any_disabled;
      logic [MASK_W-1:0] enabled_mask;
   } breaker_status_type;

   class breaker_scoreboard;

      logic [COUNT_W-1:0] fault_cnt  [NUM_UNITS_DEF];
      bit                 unit_on    [NUM_UNITS_DEF];
      logic [COUNT_W-1:0] recoveries [NUM_UNITS_DEF];
      logic [NOW_W-1:0]   retry_at   [NUM_UNITS_DEF];
      logic [NOW_W-1:0]   last_time;
      cfg_type            cfg;
      breaker_status_type status_q[$];
      int                 errors;

      function new();
         cfg.retry_limit       = RETRY_LIMIT_RST;
         cfg.cooldown_ticks    = COOLDOWN_RST;
         cfg.max_backoff_ticks = MAX_BACKOFF_RST;
         cfg.attempt_limit     = ATTEMPT_LIMIT_RST;
         cfg.auto_mask         = AUTO_MASK_RST;
         for (int u = 0; u < NUM_UNITS_DEF; u++) begin
            fault_cnt[u]  = '0;
            unit_on[u]    = 1'b1;
            recoveries[u] = '0;
            retry_at[u]   = '0;
         end
         last_time = '0;
         errors    = 0;
      endfunction

      function void set_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_RETRY_LIMIT:   cfg.retry_limit       = val[COUNT_W-1:0];
            CSR_COOLDOWN:      cfg.cooldown_ticks    = val[COOLDOWN_W-1:0];
            CSR_MAX_BACKOFF:   cfg.max_backoff_ticks = val[BACKOFF_W-1:0];
            CSR_ATTEMPT_LIMIT: cfg.attempt_limit     = val[COUNT_W-1:0];
            CSR_AUTO_MASK:     cfg.auto_mask         = val[MASK_W-1:0];
            default: ;
         endcase
      endfunction

      function bit can_retry(int u);
         return cfg.attempt_limit == '0 || recoveries[u] < cfg.attempt_limit;
      endfunction

      // cooldown * 2^min(attempts, cap), zero cooldown counts as one tick
      function logic [NOW_W-1:0] backoff_of(int u);
         logic [NOW_W:0] delay;
         int             shift;
         shift = (recoveries[u] > BACKOFF_SHIFT_CAP_DEF) ? BACKOFF_SHIFT_CAP_DEF
                                                         : int'(recoveries[u]);
         delay = (cfg.cooldown_ticks == '0) ? 33'd1 : 33'(cfg.cooldown_ticks);
         delay = delay << shift;
         if (delay > {1'b0, cfg.max_backoff_ticks})
            delay = {1'b0, cfg.max_backoff_ticks};
         return delay[NOW_W-1:0];
      endfunction

      function int pending();
         return status_q.size();
      endfunction

      function void note_request(mode_type m, logic [UNIT_ID_W-1:0] uid, logic [NOW_W-1:0] now);
         breaker_status_type want;
         logic [NOW_W-1:0]   delay;
         logic [NOW_W-1:0]   room;
         want = '0;
         case (m)
            MODE_FAULT: begin
               if (fault_cnt[uid] != {COUNT_W{1'b1}})
                  fault_cnt[uid]++;
               if (fault_cnt[uid] >= cfg.retry_limit) begin
                  delay = backoff_of(uid);
                  room  = {NOW_W{1'b1}} - last_time;
                  unit_on[uid]       = 1'b0;
                  want.just_disabled = 1'b1;
                  retry_at[uid] = (delay > room) ? {NOW_W{1'b1}} : last_time + delay;
               end
            end
            MODE_TIME: begin
               last_time = now;
               for (int u = 0; u < NUM_UNITS_DEF; u++) begin
                  if (!unit_on[u] && cfg.auto_mask[u] && can_retry(u) && now >= retry_at[u]) begin
                     if (recoveries[u] != {COUNT_W{1'b1}})
                        recoveries[u]++;
                     fault_cnt[u]           = '0;
                     unit_on[u]             = 1'b1;
                     want.recovered_mask[u] = 1'b1;
                  end
               end
            end
            MODE_RST_ONE: begin
               fault_cnt[uid] = '0;
               unit_on[uid]   = 1'b1;
            end
            MODE_RST_ALL: begin
               for (int u = 0; u < NUM_UNITS_DEF; u++) begin
                  fault_cnt[u] = '0;
                  unit_on[u]   = 1'b1;
               end
            end
            default: ;
         endcase
         for (int u = 0; u < NUM_UNITS_DEF; u++) begin
            want.enabled_mask[u] = unit_on[u];
            if (!unit_on[u])
               want.any_disabled = 1'b1;
         end
         want.fault_count = fault_cnt[uid];
         want.exhausted   = !unit_on[uid] && cfg.auto_mask[uid] && !can_retry(uid);
         status_q.push_back(want);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("%0t tb_top: mismatch %s: got %0h, expected %0h", $time, what, got, want);
         errors++;
      endtask

      task check_response(logic [RSP_DATA_W-1:0] data);
         breaker_status_type got;
         breaker_status_type want;
         got = data[$bits(breaker_status_type)-1:0];
         if (status_q.size() == 0) begin
            report("unexpected transaction", 32'(got.enabled_mask), 32'd0);
            return;
         end
         want = status_q.pop_front();
         if (got.enabled_mask !== want.enabled_mask)
            report("enabled_mask", 32'(got.enabled_mask), 32'(want.enabled_mask));
         if (got.any_disabled !== want.any_disabled)
            report("any_disabled", 32'(got.any_disabled), 32'(want.any_disabled));
         if (got.fault_count !== want.fault_count)
            report("unit_fault_count", 32'(got.fault_count), 32'(want.fault_count));
         if (got.just_disabled !== want.just_disabled)
            report("just_disabled", 32'(got.just_disabled), 32'(want.just_disabled));
         if (got.recovered_mask !== want.recovered_mask)
            report("recovered_mask", 32'(got.recovered_mask), 32'(want.recovered_mask));
         if (got.exhausted !== want.exhausted)
            report("recovery_exhausted", 32'(got.exhausted), 32'(want.exhausted));
      endtask

   endclass

endpackage

@@ tb/sv/tb_top.sv @@
// Top-level testbench: clock, reset, stream and register drivers, response monitor.
`timescale 1ns / 1ps

module tb_top;

   import fibr_pkg::*;
   import fibr_tb_pkg::*;

   localparam int STALL_LIMIT = 2000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // unit_id[3:0], now_time[35:4]
   logic [1:0]            req_tuser;   // mode[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // enabled_mask[15:0], any_disabled[16], unit_fault_count[24:17],
   // just_disabled[25], recovered_mask[41:26], recovery_exhausted[42]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   breaker_scoreboard sb;
   logic [NOW_W-1:0]  cur_time;
   int                calm_left;
   int                idle_cycles;

   fault_isolation_backoff_recovery_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // mostly short gaps, a few long ones, and now and then a stretch with none
   function automatic int idle_gap();
      int pick;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) begin
         calm_left = $urandom_range(10, 40);
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40)
         return 0;
      else if (pick < 90)
         return $urandom_range(1, 4);
      else if (pick < 97)
         return $urandom_range(5, 20);
      else
         return $urandom_range(21, 60);
   endfunction

   task automatic send_request(input mode_type m, input logic [UNIT_ID_W-1:0] uid,
                               input logic [NOW_W-1:0] now);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= m;
      req_tdata  <= {4'b0000, now, uid};
      do @(posedge clock); while (!req_tready);
      sb.note_request(m, uid, now);
      if (m == MODE_TIME)
         cur_time = now;
   endtask

   // registers change only with the block drained and quiet
   task automatic configure(input logic [7:0] retry, input logic [15:0] cool,
                            input logic [31:0] cap, input logic [7:0] tries,
                            input logic [15:0] auto);
      logic [CSR_DATA_W-1:0] vals [5];
      logic [CSR_ADDR_W-1:0] regs [5];
      vals = '{32'(retry), 32'(cool), cap, 32'(tries), 32'(auto)};
      regs = '{CSR_RETRY_LIMIT, CSR_COOLDOWN, CSR_MAX_BACKOFF, CSR_ATTEMPT_LIMIT,
               CSR_AUTO_MASK};
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (NUM_UNITS_DEF + 8) @(posedge clock);
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.set_reg(regs[i], vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   task automatic random_items(input int count);
      logic [UNIT_ID_W-1:0] hot [3];
      logic [UNIT_ID_W-1:0] uid;
      logic [NOW_W-1:0]     now;
      mode_type             m;
      int                   pick;
      for (int i = 0; i < 3; i++)
         hot[i] = 4'($urandom_range(0, 15));
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 50)
            m = MODE_FAULT;
         else if (pick < 85)
            m = MODE_TIME;
         else if (pick < 95)
            m = MODE_RST_ONE;
         else
            m = MODE_RST_ALL;
         // a few hot units so that faults pile up to the limit
         uid = ($urandom_range(0, 99) < 65) ? hot[$urandom_range(0, 2)]
                                            : 4'($urandom_range(0, 15));
         pick = $urandom_range(0, 99);
         if (pick < 80)
            now = cur_time + $urandom_range(0, 4 * int'(sb.cfg.cooldown_ticks) + 64);
         else if (pick < 90)
            now = $urandom();
         else
            now = 32'hFFFF_FFFF - $urandom_range(0, 4000);
         send_request(m, uid, now);
      end
   endtask

   // disable and recover one unit over and over until its attempt count saturates
   task automatic recycle(input logic [UNIT_ID_W-1:0] uid, input int pairs);
      send_request(MODE_TIME, uid, 32'd0);
      repeat (pairs) begin
         send_request(MODE_FAULT, uid, $urandom());
         send_request(MODE_TIME, uid, cur_time + $urandom_range(1, 8));
      end
   endtask

   // fault reports on one unit with no recovery allowed, past count saturation
   task automatic hammer(input logic [UNIT_ID_W-1:0] uid, input int count);
      repeat (count) begin
         if ($urandom_range(0, 9) == 0)
            send_request(MODE_TIME, 4'($urandom_range(0, 15)), cur_time + $urandom_range(0, 5000));
         else
            send_request(MODE_FAULT, uid, $urandom());
      end
   endtask

   initial begin
      int run;
      int gap;
      rsp_tready = 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         run = $urandom_range(1, 24);
         rsp_tready <= 1'b1;
         repeat (run) @(posedge clock);
         gap = idle_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // response check and watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles == STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      sb          = new();
      cur_time    = '0;
      calm_left   = 0;
      idle_cycles = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = MODE_FAULT;
      csr_we      = 1'b0;
      csr_addr    = CSR_RETRY_LIMIT;
      csr_wdata   = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default registers: limit reached, report on a disabled unit, recovery on time
      repeat (4) send_request(MODE_FAULT, 4'd0, 32'd0);
      send_request(MODE_TIME, 4'd0, 32'd999);
      send_request(MODE_TIME, 4'd0, 32'd1000);
      repeat (3) send_request(MODE_FAULT, 4'd15, 32'hFFFF_FFFF);
      send_request(MODE_RST_ONE, 4'd15, 32'd0);
      repeat (3) send_request(MODE_FAULT, 4'd1, 32'd0);
      send_request(MODE_RST_ALL, 4'd1, 32'd0);
      // retry time saturates near the top of the time range
      send_request(MODE_TIME, 4'd2, 32'hFFFF_FFF0);
      repeat (3) send_request(MODE_FAULT, 4'd2, 32'd0);
      send_request(MODE_TIME, 4'd2, 32'hFFFF_FFFE);
      send_request(MODE_TIME, 4'd2, 32'hFFFF_FFFF);
      send_request(MODE_TIME, 4'd7, 32'd0);
      send_request(MODE_RST_ONE, 4'd7, 32'd0);
      send_request(MODE_RST_ALL, 4'd15, 32'd0);

      // zero limit, zero cooldown, zero cap, one recovery allowed
      configure(8'd0, 16'd0, 32'd0, 8'd1, 16'hFFFF);
      random_items(120);

      configure(8'd1, 16'd1, 32'd1, 8'd0, 16'hFFFF);
      recycle(4'd9, 258);

      configure(8'd255, 16'hFFFF, 32'hFFFF_FFFF, 8'd255, 16'h0000);
      hammer(4'd6, 290);

      configure(8'd2, 16'hFFFF, 32'hFFFF_FFFF, 8'd3, 16'($urandom()));
      random_items(120);

      repeat (2) begin
         configure(8'($urandom_range(0, 6)), 16'($urandom_range(0, 3000)),
                   $urandom_range(1, 200000), 8'($urandom_range(0, 4)), 16'($urandom()));
         random_items(90);
      end

      configure(RETRY_LIMIT_RST, COOLDOWN_RST, MAX_BACKOFF_RST, ATTEMPT_LIMIT_RST,
                AUTO_MASK_RST);
      random_items(80);

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (NUM_UNITS_DEF + 8) @(posedge clock);
      if (sb.errors == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
